// File: rtl/frm_pkg.sv
// ----------------------------------------------------------------------------
// Framed range reading median package
// Shared constants and types for the distance frame parser and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

  localparam int unsigned WindowSizeDefault = 5;

  localparam int unsigned DistW = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [7:0] HeaderByte = 8'hFF;

  localparam logic [DistW-1:0] MinDistReset = 16'd30;
  localparam logic [DistW-1:0] MaxDistReset = 16'd4500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DIST = 1'b0,
    CFG_MAX_DIST = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_GOOD  = 2'd0,
    STATUS_SUM   = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

endpackage

`default_nettype wire

// File: rtl/framed_range_reading_median_top.sv
// ----------------------------------------------------------------------------
// Framed range reading median
// Parses header, high, low and sum bytes into distance frames, range checks
// them and keeps the median of a ring window of recent good distances.
// ----------------------------------------------------------------------------
// A byte that does not end a frame leaves the parser ready for the next byte.
// The sum byte of a rejected frame goes straight to the emit state, where its
// transaction is offered once the output register is free. A good frame
// rescans the window with one shared less-than and one shared equality
// comparator: each filled entry in turn is latched as candidate, then the
// smaller and equal values among all filled entries are counted, stopping at
// the median. The input is not ready during that scan. A finished result
// waits in an output register while further bytes are taken.
`default_nettype none

module framed_range_reading_median_top #(
  parameter int unsigned WINDOW_SIZE = frm_pkg::WindowSizeDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [frm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [frm_pkg::DistW-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         frame_status_o,
  output logic [frm_pkg::DistW-1:0]          frame_distance_o,
  output logic [frm_pkg::DistW-1:0]          median_distance_o,
  output logic                               have_reading_o,
  output logic [frm_pkg::CountW-1:0]         good_frames_o,
  output logic [frm_pkg::CountW-1:0]         bad_frames_o
);

  localparam int unsigned IdxW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned CntW = $clog2(WINDOW_SIZE + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW_SIZE - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(WINDOW_SIZE);

  typedef enum logic [1:0] {
    POS_HUNT,
    POS_HIGH,
    POS_LOW,
    POS_SUM
  } pos_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP,
    ST_EMIT
  } st_e;

  st_e                        st_q;
  pos_e                       pos_q;
  logic [7:0]                 high_q;
  logic [7:0]                 low_q;
  logic [frm_pkg::DistW-1:0]  min_q;
  logic [frm_pkg::DistW-1:0]  max_q;
  logic [frm_pkg::DistW-1:0]  win_q [WINDOW_SIZE];
  logic [CntW-1:0]            fill_q;
  logic [IdxW-1:0]            wp_q;
  logic [IdxW-1:0]            i_q;
  logic [IdxW-1:0]            j_q;
  logic [CntW-1:0]            lt_q;
  logic [CntW-1:0]            eq_q;
  logic [frm_pkg::DistW-1:0]  cand_q;
  logic [frm_pkg::DistW-1:0]  med_q;
  logic [frm_pkg::CountW-1:0] good_q;
  logic [frm_pkg::CountW-1:0] bad_q;
  frm_pkg::status_e           status_q;
  logic [frm_pkg::DistW-1:0]  dist_q;

  logic                       out_valid_q;
  logic [1:0]                 out_status_q;
  logic [frm_pkg::DistW-1:0]  out_dist_q;
  logic [frm_pkg::DistW-1:0]  out_med_q;
  logic                       out_have_q;
  logic [frm_pkg::CountW-1:0] out_good_q;
  logic [frm_pkg::CountW-1:0] out_bad_q;

  logic                       in_fire;
  logic                       frame_end;
  logic [frm_pkg::DistW-1:0]  in_dist;
  logic [7:0]                 sum_calc;
  logic                       sum_ok;
  logic                       range_ok;
  logic                       good_frame;
  logic [frm_pkg::DistW-1:0]  rd_data;
  logic [CntW-1:0]            lt_d;
  logic [CntW-1:0]            eq_d;
  logic [CntW:0]              lt_eq_sum;
  logic [CntW-1:0]            mid_pos;
  logic                       scan_last;
  logic                       is_median;
  logic                       out_free;

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign frame_end  = in_fire && (pos_q == POS_SUM);
  assign in_dist    = {high_q, low_q};
  assign sum_calc   = frm_pkg::HeaderByte + high_q + low_q;
  assign sum_ok     = (sum_calc == rx_byte_i);
  assign range_ok   = (in_dist >= min_q) && (in_dist <= max_q);
  assign good_frame = sum_ok && range_ok;

  assign rd_data   = win_q[j_q];
  assign lt_d      = lt_q + CntW'(rd_data < cand_q);
  assign eq_d      = eq_q + CntW'(rd_data == cand_q);
  assign lt_eq_sum = {1'b0, lt_d} + {1'b0, eq_d};
  assign mid_pos   = fill_q >> 1;
  assign scan_last = ((CntW'(j_q) + CntW'(1)) == fill_q);
  assign is_median = (lt_d <= mid_pos) && ({1'b0, mid_pos} < lt_eq_sum);
  assign out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (frame_end && good_frame) begin
      win_q[wp_q] <= in_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      pos_q        <= POS_HUNT;
      high_q       <= '0;
      low_q        <= '0;
      min_q        <= frm_pkg::MinDistReset;
      max_q        <= frm_pkg::MaxDistReset;
      fill_q       <= '0;
      wp_q         <= '0;
      i_q          <= '0;
      j_q          <= '0;
      lt_q         <= '0;
      eq_q         <= '0;
      cand_q       <= '0;
      med_q        <= '0;
      good_q       <= '0;
      bad_q        <= '0;
      status_q     <= frm_pkg::STATUS_GOOD;
      dist_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_dist_q   <= '0;
      out_med_q    <= '0;
      out_have_q   <= 1'b0;
      out_good_q   <= '0;
      out_bad_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          frm_pkg::CFG_MIN_DIST: min_q <= cfg_wdata_i;
          frm_pkg::CFG_MAX_DIST: max_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i && (st_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (pos_q)
              POS_HUNT: begin
                if (rx_byte_i == frm_pkg::HeaderByte) begin
                  pos_q <= POS_HIGH;
                end
              end
              POS_HIGH: begin
                high_q <= rx_byte_i;
                pos_q  <= POS_LOW;
              end
              POS_LOW: begin
                low_q <= rx_byte_i;
                pos_q <= POS_SUM;
              end
              default: begin
                pos_q  <= POS_HUNT;
                dist_q <= in_dist;
                if (!sum_ok) begin
                  status_q <= frm_pkg::STATUS_SUM;
                  bad_q    <= bad_q + 1'b1;
                  st_q     <= ST_EMIT;
                end else if (!range_ok) begin
                  status_q <= frm_pkg::STATUS_RANGE;
                  bad_q    <= bad_q + 1'b1;
                  st_q     <= ST_EMIT;
                end else begin
                  status_q <= frm_pkg::STATUS_GOOD;
                  good_q   <= good_q + 1'b1;
                  wp_q     <= (wp_q == LastIdx) ? '0 : wp_q + 1'b1;
                  if (fill_q != FullCnt) begin
                    fill_q <= fill_q + 1'b1;
                  end
                  i_q  <= '0;
                  st_q <= ST_LOAD;
                end
              end
            endcase
          end
        end
        ST_LOAD: begin
          cand_q <= win_q[i_q];
          j_q    <= '0;
          lt_q   <= '0;
          eq_q   <= '0;
          st_q   <= ST_CMP;
        end
        ST_CMP: begin
          lt_q <= lt_d;
          eq_q <= eq_d;
          j_q  <= j_q + 1'b1;
          if (scan_last) begin
            if (is_median) begin
              med_q <= cand_q;
              st_q  <= ST_EMIT;
            end else begin
              i_q  <= i_q + 1'b1;
              st_q <= ST_LOAD;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_dist_q   <= dist_q;
            out_med_q    <= med_q;
            out_have_q   <= (fill_q != '0);
            out_good_q   <= good_q;
            out_bad_q    <= bad_q;
            st_q         <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_status_o    = out_status_q;
  assign frame_distance_o  = out_dist_q;
  assign median_distance_o = out_med_q;
  assign have_reading_o    = out_have_q;
  assign good_frames_o     = out_good_q;
  assign bad_frames_o      = out_bad_q;

endmodule

`default_nettype wire

// File: rtl/frm_checker.sv
// ----------------------------------------------------------------------------
// Framed range reading median checker
// Port level properties of the frame parser, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [1:0]                    frame_status_o,
  input wire logic [frm_pkg::DistW-1:0]     frame_distance_o,
  input wire logic [frm_pkg::DistW-1:0]     median_distance_o,
  input wire logic                          have_reading_o,
  input wire logic [frm_pkg::CountW-1:0]    good_frames_o,
  input wire logic [frm_pkg::CountW-1:0]    bad_frames_o
);

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=>
        out_valid_o && $stable(frame_distance_o) && $stable(good_frames_o)
        && $stable(bad_frames_o);
  endproperty
  a_out_hold: assert property (p_out_hold)
    else $error("result changed while stalled");

  property p_status_legal;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (frame_status_o == frm_pkg::STATUS_GOOD)
        || (frame_status_o == frm_pkg::STATUS_SUM)
        || (frame_status_o == frm_pkg::STATUS_RANGE);
  endproperty
  a_status_legal: assert property (p_status_legal)
    else $error("illegal frame status");

  property p_empty_median;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !have_reading_o |-> median_distance_o == '0;
  endproperty
  a_empty_median: assert property (p_empty_median)
    else $error("median nonzero with empty window");

  property p_good_has_reading;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (frame_status_o == frm_pkg::STATUS_GOOD) |->
        have_reading_o && (good_frames_o != '0);
  endproperty
  a_good_has_reading: assert property (p_good_has_reading)
    else $error("good frame without a reading");

endmodule

bind framed_range_reading_median_top frm_checker u_frm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .frame_status_o    (frame_status_o),
  .frame_distance_o  (frame_distance_o),
  .median_distance_o (median_distance_o),
  .have_reading_o    (have_reading_o),
  .good_frames_o     (good_frames_o),
  .bad_frames_o      (bad_frames_o)
);

`default_nettype wire

// File: dv/framed_range_reading_median_checker.sv
// ----------------------------------------------------------------------------
// Framed range reading median checker
// Watches the byte, result and register channels of the frame parser, keeps
// its own copy of the parser, window and counters, and compares every result
// transaction field by field with the oldest predicted frame report.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_range_reading_median_checker #(
  parameter int unsigned WINDOW_SIZE = frm_pkg::WindowSizeDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [frm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [frm_pkg::DistW-1:0]    cfg_wdata_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire logic [7:0]                   rx_byte_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic [1:0]                   frame_status_i,
  input  wire logic [frm_pkg::DistW-1:0]    frame_distance_i,
  input  wire logic [frm_pkg::DistW-1:0]    median_distance_i,
  input  wire logic                         have_reading_i,
  input  wire logic [frm_pkg::CountW-1:0]   good_frames_i,
  input  wire logic [frm_pkg::CountW-1:0]   bad_frames_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       frames_pending_o
);

  localparam logic [1:0] PosHunt = 2'd0;
  localparam logic [1:0] PosHigh = 2'd1;
  localparam logic [1:0] PosLow  = 2'd2;
  localparam logic [1:0] PosSum  = 2'd3;

  typedef struct packed {
    frm_pkg::status_e            status;
    logic [frm_pkg::DistW-1:0]   distance;
    logic [frm_pkg::DistW-1:0]   median;
    logic                        has_sample;
    logic [frm_pkg::CountW-1:0]  good;
    logic [frm_pkg::CountW-1:0]  bad;
  } frame_report_t;

  frame_report_t               frame_reports_q[$];
  logic [1:0]                  byte_pos;
  logic [7:0]                  high_q;
  logic [7:0]                  low_q;
  logic [frm_pkg::DistW-1:0]   window_q [WINDOW_SIZE];
  int unsigned                 fill_cnt;
  int unsigned                 wr_pos;
  logic [frm_pkg::CountW-1:0]  good_cnt;
  logic [frm_pkg::CountW-1:0]  bad_cnt;
  logic [frm_pkg::DistW-1:0]   min_dist;
  logic [frm_pkg::DistW-1:0]   max_dist;
  int unsigned                 mismatches = 0;

  function automatic logic [frm_pkg::DistW-1:0] window_median();
    logic [frm_pkg::DistW-1:0] sorted [WINDOW_SIZE];
    logic [frm_pkg::DistW-1:0] key;
    int k;
    if (fill_cnt == 0) return '0;
    for (int i = 0; i < fill_cnt; i++) sorted[i] = window_q[i];
    for (int i = 1; i < fill_cnt; i++) begin
      key = sorted[i];
      k = i;
      while (k > 0 && sorted[k-1] > key) begin
        sorted[k] = sorted[k-1];
        k--;
      end
      sorted[k] = key;
    end
    return sorted[fill_cnt/2];
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  task automatic take_byte(input logic [7:0] b);
    frame_report_t rep;
    logic [frm_pkg::DistW-1:0] frame_dist;
    logic [7:0] sum;
    case (byte_pos)
      PosHunt: begin
        if (b == frm_pkg::HeaderByte) byte_pos = PosHigh;
      end
      PosHigh: begin
        high_q = b;
        byte_pos = PosLow;
      end
      PosLow: begin
        low_q = b;
        byte_pos = PosSum;
      end
      default: begin
        byte_pos = PosHunt;
        frame_dist = {high_q, low_q};
        sum = frm_pkg::HeaderByte + high_q + low_q;
        if (sum != b) begin
          rep.status = frm_pkg::STATUS_SUM;
          bad_cnt++;
        end else if (frame_dist < min_dist || frame_dist > max_dist) begin
          rep.status = frm_pkg::STATUS_RANGE;
          bad_cnt++;
        end else begin
          rep.status = frm_pkg::STATUS_GOOD;
          window_q[wr_pos] = frame_dist;
          wr_pos = (wr_pos + 1) % WINDOW_SIZE;
          if (fill_cnt < WINDOW_SIZE) fill_cnt++;
          good_cnt++;
        end
        rep.distance = frame_dist;
        rep.median = window_median();
        rep.has_sample = (fill_cnt > 0);
        rep.good = good_cnt;
        rep.bad = bad_cnt;
        frame_reports_q.push_back(rep);
      end
    endcase
  endtask

  task automatic check_frame();
    frame_report_t want;
    if (frame_reports_q.size() == 0) begin
      flag_mismatch("unexpected frame transaction", 0, frame_distance_i);
      return;
    end
    want = frame_reports_q.pop_front();
    if (frame_status_i != want.status)
      flag_mismatch("frame_status", want.status, frame_status_i);
    if (frame_distance_i != want.distance)
      flag_mismatch("frame_distance", want.distance, frame_distance_i);
    if (median_distance_i != want.median)
      flag_mismatch("median_distance", want.median, median_distance_i);
    if (have_reading_i != want.has_sample)
      flag_mismatch("have_reading", want.has_sample, have_reading_i);
    if (good_frames_i != want.good)
      flag_mismatch("good_frames", want.good, good_frames_i);
    if (bad_frames_i != want.bad)
      flag_mismatch("bad_frames", want.bad, bad_frames_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_reports_q.delete();
      byte_pos = PosHunt;
      high_q = '0;
      low_q = '0;
      fill_cnt = 0;
      wr_pos = 0;
      good_cnt = '0;
      bad_cnt = '0;
      min_dist = frm_pkg::MinDistReset;
      max_dist = frm_pkg::MaxDistReset;
    end else begin
      if (out_valid_i && out_ready_i) check_frame();
      if (in_valid_i && in_ready_i) take_byte(rx_byte_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          frm_pkg::CFG_MIN_DIST: min_dist = cfg_wdata_i;
          frm_pkg::CFG_MAX_DIST: max_dist = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    fail_count_o = mismatches;
    frames_pending_o = frame_reports_q.size();
  end

endmodule

`default_nettype wire

// File: dv/framed_range_reading_median_top_test.sv
// ----------------------------------------------------------------------------
// Framed range reading median testbench
// Feeds directed and random byte streams of distance frames through the
// parser under several range limits with random gaps and result stalls, and
// reports the verdict from the checker's mismatch and pending frame counts.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_range_reading_median_top_test;

  localparam int unsigned SettleCycles = 40;
  localparam int unsigned PhaseBytes = 290;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [frm_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [frm_pkg::DistW-1:0]   cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [7:0]                  rx_byte_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [1:0]                  frame_status_o;
  logic [frm_pkg::DistW-1:0]   frame_distance_o;
  logic [frm_pkg::DistW-1:0]   median_distance_o;
  logic                        have_reading_o;
  logic [frm_pkg::CountW-1:0]  good_frames_o;
  logic [frm_pkg::CountW-1:0]  bad_frames_o;
  int unsigned                 fail_count;
  int unsigned                 frames_pending;

  bit                          calm;
  logic [frm_pkg::DistW-1:0]   lim_min;
  logic [frm_pkg::DistW-1:0]   lim_max;
  int unsigned                 bytes_sent;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  framed_range_reading_median_top #(
    .WINDOW_SIZE(frm_pkg::WindowSizeDefault)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .frame_status_o,
    .frame_distance_o,
    .median_distance_o,
    .have_reading_o,
    .good_frames_o,
    .bad_frames_o
  );

  framed_range_reading_median_checker #(
    .WINDOW_SIZE(frm_pkg::WindowSizeDefault)
  ) checker_i (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i(in_ready_o),
    .rx_byte_i,
    .out_valid_i(out_valid_o),
    .out_ready_i,
    .frame_status_i(frame_status_o),
    .frame_distance_i(frame_distance_o),
    .median_distance_i(median_distance_o),
    .have_reading_i(have_reading_o),
    .good_frames_i(good_frames_o),
    .bad_frames_i(bad_frames_o),
    .fail_count_o(fail_count),
    .frames_pending_o(frames_pending)
  );

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [frm_pkg::DistW-1:0] frame_dist, input bit sum_ok);
    logic [7:0] sum;
    sum = frm_pkg::HeaderByte + frame_dist[15:8] + frame_dist[7:0];
    if (!sum_ok) sum = sum + 8'($urandom_range(1, 255));
    send_byte(frm_pkg::HeaderByte);
    send_byte(frame_dist[15:8]);
    send_byte(frame_dist[7:0]);
    send_byte(sum);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frames_pending != 0) @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [frm_pkg::DistW-1:0] lo,
                            input logic [frm_pkg::DistW-1:0] hi);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= frm_pkg::CFG_MIN_DIST;
    cfg_wdata_i <= lo;
    @(negedge clk_i);
    cfg_idx_i <= frm_pkg::CFG_MAX_DIST;
    cfg_wdata_i <= hi;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    lim_min = lo;
    lim_max = hi;
  endtask

  task automatic send_random_frame();
    logic [frm_pkg::DistW-1:0] frame_dist;
    int unsigned kind;
    int unsigned pick;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (kind < 6) begin
      send_byte(8'($urandom_range(0, 254)));
    end else if (kind < 10) begin
      send_byte(frm_pkg::HeaderByte);
      repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      if (pick < 55 && lim_min <= lim_max) begin
        frame_dist = frm_pkg::DistW'($urandom_range(lim_min, lim_max));
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0: frame_dist = lim_min;
          1: frame_dist = lim_max;
          2: frame_dist = lim_min - 1'b1;
          default: frame_dist = lim_max + 1'b1;
        endcase
      end else if (pick < 82) begin
        frame_dist = {frm_pkg::HeaderByte, 8'($urandom_range(0, 255))};
      end else if (pick < 86) begin
        frame_dist = {8'($urandom_range(0, 255)), frm_pkg::HeaderByte};
      end else begin
        frame_dist = frm_pkg::DistW'($urandom_range(0, 65535));
      end
      send_frame(frame_dist, $urandom_range(0, 99) < 85);
    end
  endtask

  task automatic run_phase(input logic [frm_pkg::DistW-1:0] lo,
                           input logic [frm_pkg::DistW-1:0] hi);
    int unsigned frames;
    set_limits(lo, hi);
    bytes_sent = 0;
    frames = 0;
    while (bytes_sent < PhaseBytes) begin
      if (frames % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 149) == 0) wait_drained();
      send_random_frame();
      frames++;
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      int unsigned stall;
      @(negedge clk_i);
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [frm_pkg::DistW-1:0] a;
    logic [frm_pkg::DistW-1:0] b;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = frm_pkg::CFG_MIN_DIST;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    calm = 1'b0;
    lim_min = frm_pkg::MinDistReset;
    lim_max = frm_pkg::MaxDistReset;
    bytes_sent = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: noise while hunting, both range edges, one past the top,
    // a bad sum and a frame whose distance bytes both equal the header byte.
    send_byte(8'h00);
    send_frame(16'd100, 1'b1);
    send_frame(frm_pkg::MinDistReset, 1'b1);
    send_frame(frm_pkg::MaxDistReset, 1'b1);
    send_frame(frm_pkg::MaxDistReset + 1'b1, 1'b1);
    send_frame(16'd200, 1'b0);
    send_frame(16'hFFFF, 1'b1);
    wait_drained();

    run_phase(16'd0, 16'hFFFF);
    run_phase(16'hFFFF, 16'd0);
    run_phase(16'd1000, 16'd1000);
    a = frm_pkg::DistW'($urandom_range(0, 60000));
    b = frm_pkg::DistW'($urandom_range(a, a + 3000));
    run_phase(a, b);
    a = frm_pkg::DistW'($urandom_range(0, 65535));
    b = frm_pkg::DistW'($urandom_range(0, 65535));
    run_phase(a, b);
    run_phase(frm_pkg::MinDistReset, frm_pkg::MaxDistReset);

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("framed_range_reading_median_top verification clean");
    end else begin
      $display("framed_range_reading_median_top verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("framed_range_reading_median_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
